### hw/rtl/assert_macros.svh
// Assertion macros for the mapper RTL.
// Expects i_clk and the active-low synchronous reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by every mapper module.
package cbm_pkg;

    localparam int PRG_BANK_BITS_DEF = 8;
    localparam int CHR_BANK_BITS_DEF = 8;

    localparam int PRG_ADDR_W  = 21;
    localparam int CHR_ADDR_W  = 18;
    localparam int CPU_ADDR_W  = 16;
    localparam int PPU_ADDR_W  = 13;
    localparam int DATA_W      = 8;
    localparam int BANK_FIELD_W = 8;
    localparam int PRG_WINDOWS = 3;
    localparam int CHR_WINDOWS = 8;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FETCH = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    // CPU address bits 15..12
    localparam logic [3:0] PAGE_PRG    = 4'h8;
    localparam logic [3:0] PAGE_CHR    = 4'hA;
    localparam logic [3:0] PAGE_IRQ    = 4'hC;
    localparam logic [3:0] PAGE_MIRROR = 4'hD;
    localparam logic [3:0] PAGE_MODE   = 4'hE;

    localparam logic [1:0] IRQ_OFS_LATCH  = 2'd1;
    localparam logic [1:0] IRQ_OFS_RELOAD = 2'd3;

    localparam logic [1:0] WIN_FIXED = 2'd3;

    localparam logic [7:0] PRG_RESET_BASE = 8'hFC;

    typedef struct packed {
        logic [1:0] mirror_mode;
        logic       irq_line;
    } t_status;

endpackage

### hw/rtl/cbm_state.sv
`timescale 1ns / 1ps
// Mapper register file: bank registers, mirroring and scanline IRQ counter.
// Depends on cbm_pkg.
module cbm_state
    import cbm_pkg::*;
#(
    parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
    parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  t_req                     i_req_type,
    input  logic [CPU_ADDR_W-1:0]    i_cpu_addr,
    input  logic [DATA_W-1:0]        i_write_data,
    output logic [PRG_BANK_BITS-1:0] o_prg_bank [PRG_WINDOWS],
    output logic [CHR_BANK_BITS-1:0] o_chr_bank [CHR_WINDOWS],
    output t_status                  o_status
);

    logic [PRG_BANK_BITS-1:0] r_prg_bank [PRG_WINDOWS];
    logic [PRG_BANK_BITS-1:0] n_prg_bank [PRG_WINDOWS];
    logic [CHR_BANK_BITS-1:0] r_chr_bank [CHR_WINDOWS];
    logic [CHR_BANK_BITS-1:0] n_chr_bank [CHR_WINDOWS];
    logic                     r_mirror, n_mirror;
    logic                     r_irq_en, n_irq_en;
    logic                     r_irq_armed, n_irq_armed;
    logic [7:0]               r_reload, n_reload;
    logic [7:0]               r_counter, n_counter;
    logic                     r_pending, n_pending;

    always_comb begin
        n_prg_bank  = r_prg_bank;
        n_chr_bank  = r_chr_bank;
        n_mirror    = r_mirror;
        n_irq_en    = r_irq_en;
        n_irq_armed = r_irq_armed;
        n_reload    = r_reload;
        n_counter   = r_counter;
        n_pending   = r_pending;
        if (i_req_type == REQ_WRITE) begin
            unique case (i_cpu_addr[15:12])
                PAGE_PRG: begin
                    // bank 3 is never selected, so it is not stored
                    for (int i = 0; i < PRG_WINDOWS; i++) begin
                        if (i_cpu_addr[1:0] == 2'(i)) begin
                            n_prg_bank[i] = i_write_data[PRG_BANK_BITS-1:0];
                        end
                    end
                end
                PAGE_CHR: begin
                    if (!i_cpu_addr[3]) begin
                        n_chr_bank[i_cpu_addr[2:0]] = i_write_data[CHR_BANK_BITS-1:0];
                    end
                end
                PAGE_IRQ: begin
                    if (i_cpu_addr[1:0] == IRQ_OFS_LATCH) begin
                        n_reload = i_write_data;
                    end else if (i_cpu_addr[1:0] == IRQ_OFS_RELOAD) begin
                        n_counter   = r_reload;
                        n_irq_armed = 1'b1;
                    end
                    n_pending = 1'b0;
                end
                PAGE_MIRROR: begin
                    n_mirror = i_write_data[0];
                end
                PAGE_MODE: begin
                    n_irq_en  = i_write_data[0];
                    n_pending = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_req_type == REQ_TICK) begin
            if (r_irq_en && r_irq_armed && r_counter != 8'd0) begin
                n_counter = r_counter - 8'd1;
                if (r_counter == 8'd1) begin
                    n_irq_armed = 1'b0;
                    n_pending   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRG_WINDOWS; i++) begin
                r_prg_bank[i] <= PRG_BANK_BITS'(PRG_RESET_BASE + 8'(i));
            end
            for (int i = 0; i < CHR_WINDOWS; i++) begin
                r_chr_bank[i] <= CHR_BANK_BITS'(i);
            end
            r_mirror    <= 1'b0;
            r_irq_en    <= 1'b0;
            r_irq_armed <= 1'b0;
            r_reload    <= 8'd0;
            r_counter   <= 8'd0;
            r_pending   <= 1'b0;
        end else if (i_go) begin
            r_prg_bank  <= n_prg_bank;
            r_chr_bank  <= n_chr_bank;
            r_mirror    <= n_mirror;
            r_irq_en    <= n_irq_en;
            r_irq_armed <= n_irq_armed;
            r_reload    <= n_reload;
            r_counter   <= n_counter;
            r_pending   <= n_pending;
        end
    end

    assign o_prg_bank = r_prg_bank;
    assign o_chr_bank = r_chr_bank;

    // status is reported after this word's update
    assign o_status.mirror_mode = {1'b0, ~n_mirror};
    assign o_status.irq_line    = n_pending;

endmodule

### hw/rtl/cbm_xlat.sv
`timescale 1ns / 1ps
// Program and pattern address translation from the current bank registers.
// Depends on cbm_pkg.
module cbm_xlat
    import cbm_pkg::*;
#(
    parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
    parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
    input  t_req                     i_req_type,
    input  logic [CPU_ADDR_W-1:0]    i_cpu_addr,
    input  logic [PPU_ADDR_W-1:0]    i_ppu_addr,
    input  logic [PRG_BANK_BITS-1:0] i_prg_bank [PRG_WINDOWS],
    input  logic [CHR_BANK_BITS-1:0] i_chr_bank [CHR_WINDOWS],
    output logic [PRG_ADDR_W-1:0]    o_prg_rom_addr,
    output logic                     o_prg_hit,
    output logic [CHR_ADDR_W-1:0]    o_chr_rom_addr
);

    logic [PRG_BANK_BITS-1:0] w_prg_sel;
    logic [CHR_BANK_BITS-1:0] w_chr_sel;

    always_comb begin
        case (i_cpu_addr[14:13])
            2'd0:      w_prg_sel = i_prg_bank[0];
            2'd1:      w_prg_sel = i_prg_bank[1];
            2'd2:      w_prg_sel = i_prg_bank[2];
            WIN_FIXED: w_prg_sel = '1;
            default:   w_prg_sel = '1;
        endcase
    end

    assign w_chr_sel = i_chr_bank[i_ppu_addr[12:10]];

    always_comb begin
        o_prg_rom_addr = '0;
        o_prg_hit      = 1'b0;
        o_chr_rom_addr = '0;
        if (i_req_type == REQ_READ && i_cpu_addr[15]) begin
            o_prg_rom_addr = {BANK_FIELD_W'(w_prg_sel), i_cpu_addr[12:0]};
            o_prg_hit      = 1'b1;
        end
        if (i_req_type == REQ_FETCH) begin
            o_chr_rom_addr = {BANK_FIELD_W'(w_chr_sel), i_ppu_addr[9:0]};
        end
    end

endmodule

### hw/rtl/cartridge_bank_mapper_scanline_irq_top.sv
`timescale 1ns / 1ps
// Cartridge bank mapper with scanline IRQ counter, top level.
// Depends on cbm_pkg, cbm_state, cbm_xlat and assert_macros.svh.
//
// Takes one request word per cycle (CPU write, CPU read translate, pattern
// fetch translate or scanline tick) and returns one result word for each.
// A word passes an input register, then the register update and address
// translation, then a result register, which it enters once the result
// register is free or being taken. One word per cycle is sustained while
// results are taken, with the input register holding a word while the
// result register is stalled. mirror_mode and irq_line reflect the state
// after the word's own update.
`include "assert_macros.svh"

module cartridge_bank_mapper_scanline_irq_top
    import cbm_pkg::*;
#(
    parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
    parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [CPU_ADDR_W-1:0] i_cpu_addr,
    input  logic [PPU_ADDR_W-1:0] i_ppu_addr,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PRG_ADDR_W-1:0] o_prg_rom_addr,
    output logic                  o_prg_hit,
    output logic [CHR_ADDR_W-1:0] o_chr_rom_addr,
    output logic [1:0]            o_mirror_mode,
    output logic                  o_irq_line
);

    logic                     r_s1_valid;
    t_req                     r_s1_req;
    logic [CPU_ADDR_W-1:0]    r_s1_cpu_addr;
    logic [PPU_ADDR_W-1:0]    r_s1_ppu_addr;
    logic [DATA_W-1:0]        r_s1_data;
    logic                     w_s1_go;

    logic                     r_out_valid;
    logic [PRG_ADDR_W-1:0]    r_out_prg_addr;
    logic                     r_out_prg_hit;
    logic [CHR_ADDR_W-1:0]    r_out_chr_addr;
    t_status                  r_out_status;

    logic [PRG_BANK_BITS-1:0] w_prg_bank [PRG_WINDOWS];
    logic [CHR_BANK_BITS-1:0] w_chr_bank [CHR_WINDOWS];
    t_status                  w_status;
    logic [PRG_ADDR_W-1:0]    w_prg_addr;
    logic                     w_prg_hit;
    logic [CHR_ADDR_W-1:0]    w_chr_addr;

    assign w_s1_go    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_req      <= t_req'(i_req_type);
            r_s1_cpu_addr <= i_cpu_addr;
            r_s1_ppu_addr <= i_ppu_addr;
            r_s1_data     <= i_write_data;
        end
        if (w_s1_go) begin
            r_out_prg_addr <= w_prg_addr;
            r_out_prg_hit  <= w_prg_hit;
            r_out_chr_addr <= w_chr_addr;
            r_out_status   <= w_status;
        end
    end

    cbm_state #(
        .PRG_BANK_BITS (PRG_BANK_BITS),
        .CHR_BANK_BITS (CHR_BANK_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (w_s1_go),
        .i_req_type   (r_s1_req),
        .i_cpu_addr   (r_s1_cpu_addr),
        .i_write_data (r_s1_data),
        .o_prg_bank   (w_prg_bank),
        .o_chr_bank   (w_chr_bank),
        .o_status     (w_status)
    );

    cbm_xlat #(
        .PRG_BANK_BITS (PRG_BANK_BITS),
        .CHR_BANK_BITS (CHR_BANK_BITS)
    ) u_xlat (
        .i_req_type     (r_s1_req),
        .i_cpu_addr     (r_s1_cpu_addr),
        .i_ppu_addr     (r_s1_ppu_addr),
        .i_prg_bank     (w_prg_bank),
        .i_chr_bank     (w_chr_bank),
        .o_prg_rom_addr (w_prg_addr),
        .o_prg_hit      (w_prg_hit),
        .o_chr_rom_addr (w_chr_addr)
    );

    assign o_out_valid    = r_out_valid;
    assign o_prg_rom_addr = r_out_prg_addr;
    assign o_prg_hit      = r_out_prg_hit;
    assign o_chr_rom_addr = r_out_chr_addr;
    assign o_mirror_mode  = r_out_status.mirror_mode;
    assign o_irq_line     = r_out_status.irq_line;

    `ASSERT_NEXT(a_prg_only_on_read, w_s1_go && r_s1_req != REQ_READ, !r_out_prg_hit && r_out_prg_addr == '0, "program address on a non-read word")
    `ASSERT_NEXT(a_chr_only_on_fetch, w_s1_go && r_s1_req != REQ_FETCH, r_out_chr_addr == '0, "pattern address on a non-fetch word")
    `ASSERT_NEXT(a_s1_holds, r_s1_valid && !w_s1_go, r_s1_valid && $stable(r_s1_cpu_addr) && $stable(r_s1_req), "input register lost a stalled word")
    `ASSERT_NOW(a_mirror_range, r_out_valid, !r_out_status.mirror_mode[1], "single-screen mirroring reported")

endmodule
